/* rtl/bpgps_pkg.sv */
// Package for the gapped pattern scanner: command codes, register indexes,
// beat payload structs. No dependencies.
package bpgps_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_LETTER = 2'd0,
        CMD_LOAD_GAP    = 2'd1,
        CMD_SCAN        = 2'd2,
        CMD_CLEAR       = 2'd3
    } cmd_t;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LIMIT      = 4'd1;

    localparam int COUNT_W = 32;

    typedef struct packed {
        cmd_t        command;
        logic [4:0]  table_index;
        logic [63:0] mask_value;
        logic [4:0]  residue;
        logic        last_in_sequence;
    } item_t;

    typedef struct packed {
        logic               match_end;
        logic [COUNT_W-1:0] total_matches;
        logic [COUNT_W-1:0] sequences_matched;
        logic               sequence_hit;
    } result_t;

endpackage

/* rtl/bit_parallel_gapped_pattern_scanner_top.sv */
// Gapped pattern scanner top level: letter mask memory, gap mask registers,
// NFA vector update and counters. Depends on bpgps_pkg.
//
// channel  | direction | handshake           | beat
// item     | in        | item_valid/stall    | bpgps_pkg::item_t
// result   | out       | result_valid/stall  | bpgps_pkg::result_t
// cfg      | in        | cfg_valid/ready     | cfg_index, cfg_data
//
// One item per cycle sustained while the result is not held. Stage one reads
// the letter mask memory (one synchronous read port); the update stage applies
// the shift-or-and update and loads the result register.
// Reset clears the vector, hit flag, counters and registers; mask tables
// are not cleared. A held result stalls the update stage, then the input.
module bit_parallel_gapped_pattern_scanner_top #(
    parameter int POSITIONS = 64,
    parameter int GAP_SLOTS = 16,
    parameter int ALPHABET  = 26
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  bpgps_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output bpgps_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpgps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpgps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW  = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int LIW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int GIW = (GAP_SLOTS > 1) ? $clog2(GAP_SLOTS) : 1;

    // Storage
    logic [POSITIONS-1:0] letter_mem [ALPHABET];
    logic [POSITIONS-1:0] gap_reg [GAP_SLOTS];

    // Configuration
    logic [AW-1:0] accept_idx_reg;
    logic [3:0]    gap_limit_reg;

    // Stage one
    logic                 s1_valid_reg, s1_valid_next;
    bpgps_pkg::cmd_t      s1_cmd_reg;
    logic                 s1_last_reg;
    logic                 s1_letter_ok_reg;
    logic [POSITIONS-1:0] s1_letter_reg;

    // NFA and counters
    logic [POSITIONS-1:0]          active_reg, active_next;
    logic                          hit_reg, hit_next;
    logic [bpgps_pkg::COUNT_W-1:0] match_cnt_reg, match_cnt_next;
    logic [bpgps_pkg::COUNT_W-1:0] seq_cnt_reg, seq_cnt_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    bpgps_pkg::result_t out_reg, out_next;

    logic                 accept;
    logic                 s1_adv;
    logic [POSITIONS-1:0] vec_calc;
    logic                 match;
    logic                 hit_shown;

    // Handshake
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall   = s1_valid_reg && !s1_adv;
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Write configuration, clamped into working form
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_idx_reg <= '0;
            gap_limit_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == bpgps_pkg::CFG_PATTERN_LENGTH)
            begin
                if (cfg_data == '0)
                    accept_idx_reg <= '0;
                else if (int'(cfg_data) > POSITIONS)
                    accept_idx_reg <= AW'(POSITIONS - 1);
                else
                    accept_idx_reg <= AW'(int'(cfg_data) - 1);
            end
            else if (cfg_index == bpgps_pkg::CFG_GAP_LIMIT)
            begin
                if (int'(cfg_data[3:0]) > GAP_SLOTS - 1)
                    gap_limit_reg <= 4'(GAP_SLOTS - 1);
                else
                    gap_limit_reg <= cfg_data[3:0];
            end
        end
    end

    // Write and read the letter mask memory
    always_ff @(posedge clk)
    begin
        if (accept && item.command == bpgps_pkg::CMD_LOAD_LETTER
            && int'(item.table_index) < ALPHABET)
            letter_mem[item.table_index[LIW-1:0]] <= item.mask_value[POSITIONS-1:0];
        if (accept && item.command == bpgps_pkg::CMD_SCAN)
            s1_letter_reg <= letter_mem[item.residue[LIW-1:0]];
    end

    // Load gap masks and stage-one payload
    always_ff @(posedge clk)
    begin
        if (accept && item.command == bpgps_pkg::CMD_LOAD_GAP
            && int'(item.table_index) < GAP_SLOTS)
            gap_reg[item.table_index[GIW-1:0]] <= item.mask_value[POSITIONS-1:0];
        if (accept)
        begin
            s1_cmd_reg       <= item.command;
            s1_last_reg      <= item.last_in_sequence;
            s1_letter_ok_reg <= int'(item.residue) < ALPHABET;
        end
    end

    // Form the next NFA vector
    always_comb
    begin
        vec_calc = (active_reg << 1) | POSITIONS'(1);
        for (int k = 1; k < GAP_SLOTS; k++)
        begin
            if (k <= int'(gap_limit_reg))
                vec_calc = vec_calc | ((active_reg & gap_reg[GIW'(k)]) << (k + 1));
        end
        vec_calc = vec_calc & (s1_letter_ok_reg ? s1_letter_reg : '0);
    end

    assign match     = (s1_cmd_reg == bpgps_pkg::CMD_SCAN) && vec_calc[accept_idx_reg];
    assign hit_shown = hit_reg || match;

    // Update state and result when stage one advances
    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        active_next    = active_reg;
        hit_next       = hit_reg;
        match_cnt_next = match_cnt_reg;
        seq_cnt_next   = seq_cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        if (s1_adv)
        begin
            case (s1_cmd_reg)
                bpgps_pkg::CMD_SCAN:
                begin
                    if (match)
                    begin
                        if (match_cnt_reg != '1)
                            match_cnt_next = match_cnt_reg + 1'b1;
                        if (!hit_reg && seq_cnt_reg != '1)
                            seq_cnt_next = seq_cnt_reg + 1'b1;
                    end
                    active_next = s1_last_reg ? '0 : vec_calc;
                    hit_next    = s1_last_reg ? 1'b0 : hit_shown;
                end
                bpgps_pkg::CMD_CLEAR:
                begin
                    match_cnt_next = '0;
                    seq_cnt_next   = '0;
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
            out_valid_next             = 1'b1;
            out_next.match_end         = match;
            out_next.total_matches     = match_cnt_next;
            out_next.sequences_matched = seq_cnt_next;
            out_next.sequence_hit      = hit_shown;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            active_reg    <= '0;
            hit_reg       <= 1'b0;
            match_cnt_reg <= '0;
            seq_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            active_reg    <= active_next;
            hit_reg       <= hit_next;
            match_cnt_reg <= match_cnt_next;
            seq_cnt_reg   <= seq_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // A reported match always marks the sequence as hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.match_end |-> out_reg.sequence_hit)
        else $error("match without sequence hit");

    // Matched sequences never outnumber match ends
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_cnt_reg <= match_cnt_reg)
        else $error("sequence count above match count");

    // Input stalls only behind a held stage-one beat
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled without backpressure");

    // A held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg && $stable(out_reg))
        else $error("held result changed");

endmodule

/* dv/bit_parallel_gapped_pattern_scanner_top_tb.sv */
// Self-checking bench for the gapped pattern scanner: drives item and register beats,
// predicts every result beat from its own NFA copy and compares it field by field.
// Depends on bpgps_pkg and bit_parallel_gapped_pattern_scanner_top.
module bit_parallel_gapped_pattern_scanner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POSITIONS   = 64;
    localparam int SHORTCUTS   = 16;
    localparam int LETTERS     = 26;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;

    localparam logic [4:0] LETTER_A = 5'd0;
    localparam logic [4:0] LETTER_Z = 5'd25;

    // Tracks NFA vector, mask tables, counters and registers; holds awaited result beats
    class nfa_match_tracker;
        logic [63:0]                      letter_tab [LETTERS];
        logic [63:0]                      gap_tab [SHORTCUTS];
        logic [63:0]                      nfa_vec;
        logic                             hit_seq;
        logic [bpgps_pkg::COUNT_W-1:0]    match_cnt;
        logic [bpgps_pkg::COUNT_W-1:0]    seq_cnt;
        logic [bpgps_pkg::CFG_DATA_W-1:0] len_reg;
        logic [3:0]                       limit_reg;
        bpgps_pkg::result_t               awaited_results[$];
        int unsigned                      failures;

        function new();
            foreach (letter_tab[i])
                letter_tab[i] = '0;
            foreach (gap_tab[i])
                gap_tab[i] = '0;
            nfa_vec   = '0;
            hit_seq   = 1'b0;
            match_cnt = '0;
            seq_cnt   = '0;
            len_reg   = 7'd1;
            limit_reg = 4'd0;
            failures  = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_register(logic [bpgps_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [bpgps_pkg::CFG_DATA_W-1:0] data);
            if (idx == bpgps_pkg::CFG_PATTERN_LENGTH)
                len_reg = data;
            else if (idx == bpgps_pkg::CFG_GAP_LIMIT)
                limit_reg = data[3:0];
        endfunction

        function logic [bpgps_pkg::COUNT_W-1:0] sat_bump(logic [bpgps_pkg::COUNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void take_item(bpgps_pkg::item_t it);
            bpgps_pkg::result_t want;
            int                 eff_len;
            logic [63:0]        nxt;
            logic [63:0]        lmask;
            want = '0;
            case (it.command)
                bpgps_pkg::CMD_LOAD_LETTER:
                begin
                    if (it.table_index < LETTERS)
                        letter_tab[it.table_index] = it.mask_value;
                end
                bpgps_pkg::CMD_LOAD_GAP:
                begin
                    if (it.table_index < SHORTCUTS)
                        gap_tab[it.table_index[3:0]] = it.mask_value;
                end
                bpgps_pkg::CMD_CLEAR:
                begin
                    match_cnt = '0;
                    seq_cnt   = '0;
                end
                default:
                begin
                    // clamp length, then shift-or with gap shortcuts and mask by letter
                    eff_len = (len_reg == 0) ? 1 : ((len_reg > POSITIONS) ? POSITIONS : len_reg);
                    nxt = (nfa_vec << 1) | 64'd1;
                    for (int k = 1; k <= limit_reg; k++)
                        nxt |= (nfa_vec & gap_tab[4'(k)]) << (k + 1);
                    lmask = (it.residue < LETTERS) ? letter_tab[it.residue] : 64'd0;
                    nfa_vec = nxt & lmask;
                    if (nfa_vec[eff_len-1])
                    begin
                        want.match_end = 1'b1;
                        match_cnt = sat_bump(match_cnt);
                        if (!hit_seq)
                            seq_cnt = sat_bump(seq_cnt);
                        hit_seq = 1'b1;
                    end
                end
            endcase
            want.total_matches     = match_cnt;
            want.sequences_matched = seq_cnt;
            want.sequence_hit      = hit_seq;
            // drop the vector and hit flag after the last residue of a sequence
            if (it.command == bpgps_pkg::CMD_SCAN && it.last_in_sequence)
            begin
                nfa_vec = '0;
                hit_seq = 1'b0;
            end
            awaited_results.push_back(want);
        endfunction

        function void check_result(bpgps_pkg::result_t got);
            bpgps_pkg::result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result beat arrived with nothing awaited");
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.match_end !== want.match_end)
            begin
                $error("match_end: expected %0d, got %0d", want.match_end, got.match_end);
                failures++;
            end
            if (got.total_matches !== want.total_matches)
            begin
                $error("total_matches: expected %0d, got %0d",
                       want.total_matches, got.total_matches);
                failures++;
            end
            if (got.sequences_matched !== want.sequences_matched)
            begin
                $error("sequences_matched: expected %0d, got %0d",
                       want.sequences_matched, got.sequences_matched);
                failures++;
            end
            if (got.sequence_hit !== want.sequence_hit)
            begin
                $error("sequence_hit: expected %0d, got %0d",
                       want.sequence_hit, got.sequence_hit);
                failures++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              item_valid;
    logic                              item_stall;
    bpgps_pkg::item_t                  item;
    logic                              result_valid;
    logic                              result_stall;
    bpgps_pkg::result_t                result;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [bpgps_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bpgps_pkg::CFG_DATA_W-1:0]  cfg_data;

    nfa_match_tracker tracker;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    bit_parallel_gapped_pattern_scanner_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop for a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Note accepted item beats and check accepted result beats
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            tracker.take_item(item);
        if (rst_n && result_valid && !result_stall)
            tracker.check_result(result);
    end

    // Random backpressure on the result channel
    always @(negedge clk)
        result_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Drive one item beat and hold it until taken; starts and ends at a falling edge
    task automatic push_item(bpgps_pkg::cmd_t c, logic [4:0] idx, logic [63:0] m,
                             logic [4:0] res, logic last);
        bpgps_pkg::item_t beat;
        beat.command          = c;
        beat.table_index      = idx;
        beat.mask_value       = m;
        beat.residue          = res;
        beat.last_in_sequence = last;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic scan(logic [4:0] res, logic last);
        push_item(bpgps_pkg::CMD_SCAN, 5'($urandom), rnd64(), res, last);
    endtask

    // Loads and clears carry random residue and last flag, which must be ignored
    task automatic send_cmd(bpgps_pkg::cmd_t c, logic [4:0] idx, logic [63:0] m);
        push_item(c, idx, m, 5'($urandom), 1'($urandom));
    endtask

    // Wait until every awaited beat is back, then idle for pipeline slack
    task automatic drain();
        item_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [bpgps_pkg::CFG_INDEX_W-1:0] idx,
                             logic [bpgps_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.note_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [4:0]                       alph [4];
        logic [4:0]                       pat_letter [POSITIONS];
        bit                               wild [POSITIONS];
        logic [63:0]                      m;
        logic [bpgps_pkg::CFG_DATA_W-1:0] len_val;
        logic [bpgps_pkg::CFG_DATA_W-1:0] lim_val;
        int                               eff_len;
        int                               goal;
        int                               pick;
        int                               run_len;

        tracker      = new();
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill both tables: letter A passes every position, Z none, gap 15 all ones
        for (int l = 0; l < LETTERS; l++)
            send_cmd(bpgps_pkg::CMD_LOAD_LETTER, 5'(l),
                     (l == LETTER_A) ? '1 : ((l == LETTER_Z) ? 64'd0 : rnd64()));
        for (int k = 0; k < SHORTCUTS; k++)
            send_cmd(bpgps_pkg::CMD_LOAD_GAP, 5'(k), (k == SHORTCUTS - 1) ? '1 : rnd64());

        // Out-of-range table indexes are dropped
        send_cmd(bpgps_pkg::CMD_LOAD_LETTER, 5'd26, 64'd0);
        send_cmd(bpgps_pkg::CMD_LOAD_LETTER, 5'd31, 64'd0);
        send_cmd(bpgps_pkg::CMD_LOAD_GAP, 5'd16, 64'd0);
        send_cmd(bpgps_pkg::CMD_LOAD_GAP, 5'd31, 64'd0);

        // Length one: match, empty mask, residues past the alphabet, end of sequence
        scan(LETTER_A, 1'b0);
        scan(LETTER_Z, 1'b0);
        scan(5'd26, 1'b0);
        scan(5'd31, 1'b0);
        scan(LETTER_A, 1'b0);
        scan(LETTER_A, 1'b1);
        // Clear keeps vector and hit flag but zeroes counters
        scan(LETTER_A, 1'b0);
        send_cmd(bpgps_pkg::CMD_CLEAR, 5'd31, '1);
        scan(LETTER_Z, 1'b0);
        scan(LETTER_A, 1'b1);

        // Longest pattern with every shortcut in use
        drain();
        write_reg(bpgps_pkg::CFG_PATTERN_LENGTH, 7'd64);
        write_reg(bpgps_pkg::CFG_GAP_LIMIT, 7'h0F);
        repeat (8) scan(LETTER_A, 1'b0);
        scan(LETTER_A, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    len_val = 7'd1;
                    lim_val = 7'h70;
                end
                1:
                begin
                    len_val = 7'd64;
                    lim_val = 7'h0F;
                end
                2:
                begin
                    len_val = 7'd0;
                    lim_val = 7'h7F;
                end
                3:
                begin
                    len_val = 7'd127;
                    lim_val = 7'($urandom);
                end
                6:
                begin
                    len_val = 7'($urandom_range(20, 64));
                    lim_val = 7'($urandom);
                end
                default:
                begin
                    len_val = 7'($urandom_range(2, 12));
                    lim_val = 7'($urandom);
                end
            endcase
            write_reg(bpgps_pkg::CFG_PATTERN_LENGTH, len_val);
            write_reg(bpgps_pkg::CFG_GAP_LIMIT, lim_val);
            send_idle_pct  = (p < 3) ? 24 : ((p < 6) ? 52 : 0);
            recv_stall_pct = (p < 3) ? 52 : ((p < 6) ? 24 : 0);
            eff_len = (len_val == 0) ? 1 : ((len_val > POSITIONS) ? POSITIONS : len_val);

            // Compile a random pattern over four letters, some positions wild
            foreach (alph[j])
                alph[j] = 5'($urandom_range(0, LETTERS - 1));
            for (int q = 0; q < POSITIONS; q++)
            begin
                pat_letter[q] = alph[$urandom_range(0, 3)];
                wild[q]       = ($urandom_range(0, 99) < 15);
            end
            for (int l = 0; l < LETTERS; l++)
            begin
                m = rnd64();
                for (int q = 0; q < eff_len; q++)
                    m[q] = wild[q] || (pat_letter[q] == l);
                send_cmd(bpgps_pkg::CMD_LOAD_LETTER, 5'(l), m);
            end
            for (int k = 0; k < SHORTCUTS; k++)
                send_cmd(bpgps_pkg::CMD_LOAD_GAP, 5'(k), rnd64() & rnd64() & rnd64());

            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_cmd(bpgps_pkg::CMD_CLEAR, 5'($urandom), rnd64());
                else if (pick < 6)
                    send_cmd(bpgps_pkg::CMD_LOAD_LETTER, 5'($urandom), rnd64());
                else if (pick < 8)
                    send_cmd(bpgps_pkg::CMD_LOAD_GAP, 5'($urandom), rnd64());
                else if (pick < 50)
                begin
                    // Short noise prefix, then the pattern itself
                    repeat ($urandom_range(0, 3)) scan(alph[$urandom_range(0, 3)], 1'b0);
                    for (int q = 0; q < eff_len; q++)
                        scan(wild[q] ? alph[$urandom_range(0, 3)] : pat_letter[q],
                             (q == eff_len - 1) && ($urandom_range(0, 99) < 70));
                end
                else
                begin
                    run_len = $urandom_range(1, 20);
                    for (int q = 0; q < run_len; q++)
                        scan(($urandom_range(0, 9) != 0) ? alph[$urandom_range(0, 3)]
                                                          : 5'($urandom),
                             q == run_len - 1);
                end
            end
        end

        drain();
        if (tracker.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
